// ===== rtl/assert_macros.svh =====
// Assertion macros for the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge, skipped while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every rising clock edge, also during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/upd_pkg.sv =====
// Types, character constants and helper functions for the URL percent decoder.
`timescale 1ns / 1ps
package upd_pkg;

  // Characters the decoder recognizes.
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // Marks a character that is not a hex digit.
  localparam logic [4:0] HEX_NONE = 5'd16;

  // Escape tracking state.
  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  // Input item.
  typedef struct packed {
    logic [7:0] char_in;
    logic       is_terminator;
  } in_t;

  // Result item.
  typedef struct packed {
    logic [7:0] char_out;
    logic       end_of_string;
    logic       last_of_run;
  } out_t;

  // All results caused by one input, in order from chars[0].
  typedef struct packed {
    logic [2:0][7:0] chars;
    logic [1:0]      cnt;
    logic            eos;
  } desc_t;

  // Value of a hex digit, or HEX_NONE when the character is not one.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = HEX_NONE;
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
      v = 5'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) begin
      v = 5'(c - CH_LOWER_A + 8'd10);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) begin
      v = 5'(c - CH_UPPER_A + 8'd10);
    end
    return v;
  endfunction

  // Character emitted for an ordinary (non-percent) character.
  function automatic logic [7:0] plain_char(input logic [7:0] c, input logic p2s);
    return (c == CH_PLUS && p2s) ? CH_SPACE : c;
  endfunction

endpackage

// ===== rtl/upd_front.sv =====
// Front end: takes input characters, tracks escapes and builds result runs.
`timescale 1ns / 1ps
module upd_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           plus_to_space,
  input  upd_pkg::in_t   item,
  input  logic           accept,
  output upd_pkg::desc_t desc,
  output logic           push
);
  import upd_pkg::*;

  phase_t     phase;
  phase_t     phase_next;
  logic [7:0] held_digit;
  logic [7:0] held_digit_next;

  logic [7:0] c;
  logic [4:0] hi_val;
  logic [4:0] lo_val;
  logic [7:0] byte_val;
  logic       tail_pct;
  logic [7:0] tail_char;

  assign c         = item.char_in;
  assign hi_val    = hex_value(held_digit);
  assign lo_val    = hex_value(c);
  assign byte_val  = {hi_val[3:0], lo_val[3:0]};
  assign tail_pct  = (c == CH_PERCENT);
  assign tail_char = plain_char(c, plus_to_space);

  // State register, updated only on a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      held_digit <= 8'd0;
    end else if (accept) begin
      phase      <= phase_next;
      held_digit <= held_digit_next;
    end
  end

  // Next state and the run of results for the current character.
  always_comb begin
    phase_next      = phase;
    held_digit_next = held_digit;
    desc            = '0;
    if (item.is_terminator) begin
      // Flush the pending escape literally, then the end marker.
      unique case (phase)
        PH_PCT: begin
          desc.chars[0] = CH_PERCENT;
          desc.cnt      = 2'd2;
        end
        PH_DIGIT: begin
          desc.chars[0] = CH_PERCENT;
          desc.chars[1] = held_digit;
          desc.cnt      = 2'd3;
        end
        default: begin
          desc.cnt = 2'd1;
        end
      endcase
      desc.eos        = 1'b1;
      phase_next      = PH_IDLE;
      held_digit_next = 8'd0;
    end else begin
      unique case (phase)
        PH_PCT: begin
          if (lo_val != HEX_NONE) begin
            held_digit_next = c;
            phase_next      = PH_DIGIT;
          end else begin
            // Malformed escape: literal percent, then this character from idle.
            desc.chars[0] = CH_PERCENT;
            if (tail_pct) begin
              desc.cnt   = 2'd1;
              phase_next = PH_PCT;
            end else begin
              desc.chars[1] = tail_char;
              desc.cnt      = 2'd2;
              phase_next    = PH_IDLE;
            end
          end
        end
        PH_DIGIT: begin
          if (lo_val != HEX_NONE && hi_val != HEX_NONE && byte_val != 8'd0) begin
            desc.chars[0] = byte_val;
            desc.cnt      = 2'd1;
            phase_next    = PH_IDLE;
          end else begin
            // Bad second digit or an escaped zero: emit both held characters.
            desc.chars[0] = CH_PERCENT;
            desc.chars[1] = held_digit;
            if (tail_pct) begin
              desc.cnt   = 2'd2;
              phase_next = PH_PCT;
            end else begin
              desc.chars[2] = tail_char;
              desc.cnt      = 2'd3;
              phase_next    = PH_IDLE;
            end
          end
        end
        default: begin
          if (tail_pct) begin
            phase_next = PH_PCT;
          end else begin
            desc.chars[0] = tail_char;
            desc.cnt      = 2'd1;
            phase_next    = PH_IDLE;
          end
        end
      endcase
    end
  end

  assign push = accept && (desc.cnt != 2'd0);

endmodule

// ===== rtl/upd_fifo.sv =====
// Short queue of result runs between the front end and the output side.
`timescale 1ns / 1ps
module upd_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  upd_pkg::desc_t wr_data,
  input  logic           pop,
  output upd_pkg::desc_t rd_data,
  output logic           full,
  output logic           empty
);
  import upd_pkg::*;
`include "assert_macros.svh"

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t             entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign rd_data = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_CLK(a_no_push_full, !(push && full), "push into a full queue")
  `ASSERT_CLK(a_no_pop_empty, !(pop && empty), "pop from an empty queue")
  `ASSERT_CLK(a_count_up, (push && !pop) |=> (count == $past(count) + 1'b1), "count did not rise")
  `ASSERT_CLK(a_count_range, count <= CNT_W'(DEPTH), "count beyond depth")

endmodule

// ===== rtl/upd_back.sv =====
// Output side: walks each queued run and presents one result per cycle while out_ready is high.
`timescale 1ns / 1ps
module upd_back (
  input  logic           clk,
  input  logic           rst,
  input  upd_pkg::desc_t head,
  input  logic           head_valid,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output upd_pkg::out_t  out_data
);
  import upd_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       last_here;

  // A new result enters the output register when it is empty or being taken.
  assign load      = head_valid && (!out_valid || out_ready);
  assign last_here = (idx == 2'(head.cnt - 2'd1));
  assign pop       = load && last_here;

  // Control: output valid and position within the current run.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      out_valid <= 1'b1;
      idx       <= last_here ? 2'd0 : idx + 2'd1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      out_data.char_out      <= head.chars[idx];
      out_data.end_of_string <= head.eos && last_here;
      out_data.last_of_run   <= last_here;
    end
  end

endmodule

// ===== rtl/url_percent_decoder.sv =====
// Top level of the streaming URL percent decoder.
`timescale 1ns / 1ps
// The decoder accepts one character per cycle while its run queue has room and
// delivers one result per cycle from a registered output while out_ready is
// high. Each input is turned at once into a run of zero to three results (a
// decoded byte, literal flushes of a broken escape, or the end marker), which
// waits in a FIFO_DEPTH-entry queue; an input with a run of n results therefore
// holds the output side for n results, and the input side stalls only when that
// queue is full. The plus_to_space register resets to 1.
module url_percent_decoder #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  upd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output upd_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);
  import upd_pkg::*;

  logic  plus_to_space;
  logic  accept;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  desc_t push_desc;
  desc_t head_desc;

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      plus_to_space <= 1'b1;
    end else if (cfg_we) begin
      plus_to_space <= cfg_wdata;
    end
  end

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  upd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .plus_to_space (plus_to_space),
    .item          (in_data),
    .accept        (accept),
    .desc          (push_desc),
    .push          (push)
  );

  upd_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_desc),
    .pop     (pop),
    .rd_data (head_desc),
    .full    (full),
    .empty   (empty)
  );

  upd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_desc),
    .head_valid (!empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== dv/url_percent_decoder_tb.sv =====
// Self-checking testbench for the streaming URL percent decoder.
`timescale 1ns / 1ps
module url_percent_decoder_tb;
  import upd_pkg::*;

  // One row of the directed stimulus: the input transfer, and when known_run is set,
  // the run of results typed in by hand (the end marker counts as a result).
  typedef struct packed {
    logic [7:0] ch;
    logic       term;
    logic       known_run;
    logic [1:0] run_cnt;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] r2;
  } dir_row_t;

  localparam int NUM_DIR_ROWS = 25;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int DRAIN_CYCLES = 8;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;

  // Decoder state as this testbench sees it.
  logic space_for_plus = 1'b1;
  phase_t esc_state = PH_IDLE;
  logic [7:0] held_char = '0;

  // Results of the latest input, and all results still owed by the block.
  out_t run_buf [3];
  int run_len;
  out_t decoded_q [$];

  int mismatches = 0;
  logic bursts_on = 1'b1;
  int stall_left = 0;
  dir_row_t dir_rows [NUM_DIR_ROWS];

  url_percent_decoder i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Value of a hex digit character, or -1 for anything else.
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= CH_ZERO && c <= CH_ZERO + 8'd9) begin
      return int'(c - CH_ZERO);
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_A + 8'd5) begin
      return int'(c - CH_LOWER_A) + 10;
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_A + 8'd5) begin
      return int'(c - CH_UPPER_A) + 10;
    end
    return -1;
  endfunction

  // A random hex digit character in either case.
  function automatic logic [7:0] rand_hex_char();
    logic [7:0] v;
    v = 8'($urandom_range(0, 15));
    if (v < 8'd10) begin
      return CH_ZERO + v;
    end else if ($urandom_range(0, 1) == 1) begin
      return CH_LOWER_A + v - 8'd10;
    end
    return CH_UPPER_A + v - 8'd10;
  endfunction

  task automatic emit(input logic [7:0] ch, input logic eos);
    run_buf[run_len] = '{char_out: ch, end_of_string: eos, last_of_run: 1'b0};
    run_len++;
  endtask

  // A character seen from the idle state: opens an escape or passes through.
  task automatic take_plain(input logic [7:0] c);
    if (c == CH_PERCENT) begin
      esc_state = PH_PCT;
    end else if (c == CH_PLUS && space_for_plus) begin
      emit(CH_SPACE, 1'b0);
    end else begin
      emit(c, 1'b0);
    end
  endtask

  // Works out the run of results for one input transfer and advances the state.
  task automatic decode_step(input in_t it);
    int hi;
    int lo;
    run_len = 0;
    if (it.is_terminator) begin
      if (esc_state == PH_PCT) begin
        emit(CH_PERCENT, 1'b0);
      end else if (esc_state == PH_DIGIT) begin
        emit(CH_PERCENT, 1'b0);
        emit(held_char, 1'b0);
      end
      emit(8'h00, 1'b1);
      esc_state = PH_IDLE;
      held_char = '0;
    end else if (esc_state == PH_PCT) begin
      if (hex_nibble(it.char_in) >= 0) begin
        held_char = it.char_in;
        esc_state = PH_DIGIT;
      end else begin
        emit(CH_PERCENT, 1'b0);
        esc_state = PH_IDLE;
        take_plain(it.char_in);
      end
    end else if (esc_state == PH_DIGIT) begin
      hi = hex_nibble(held_char);
      lo = hex_nibble(it.char_in);
      esc_state = PH_IDLE;
      if (hi >= 0 && lo >= 0 && (hi * 16 + lo) != 0) begin
        emit(8'(hi * 16 + lo), 1'b0);
      end else begin
        emit(CH_PERCENT, 1'b0);
        emit(held_char, 1'b0);
        take_plain(it.char_in);
      end
    end else begin
      esc_state = PH_IDLE;
      take_plain(it.char_in);
    end
    if (run_len > 0) begin
      run_buf[run_len - 1].last_of_run = 1'b1;
    end
  endtask

  task automatic queue_run();
    for (int i = 0; i < run_len; i++) begin
      decoded_q.push_back(run_buf[i]);
    end
  endtask

  // Presents one input, with an occasional idle burst first, and returns on its transfer.
  task automatic deliver(input in_t it);
    if (bursts_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(posedge clk);
    end while (!in_ready);
  endtask

  task automatic deliver_and_predict(input in_t it);
    deliver(it);
    decode_step(it);
    queue_run();
  endtask

  // Waits for the block to drain, then writes the plus mode register and sets the burst mode.
  task automatic set_plus_mode(input logic mode, input logic keep_bursts);
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= mode;
    bursts_on <= keep_bursts;
    @(posedge clk);
    cfg_we <= 1'b0;
    space_for_plus = mode;
  endtask

  // Random traffic: well-formed escapes mixed with broken ones, terminators and noise.
  task automatic run_random(input int count);
    in_t seq [$];
    int sent;
    int pick;
    sent = 0;
    while (sent < count) begin
      seq.delete();
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        seq.push_back('{char_in: CH_PERCENT, is_terminator: 1'b0});
        seq.push_back('{char_in: rand_hex_char(), is_terminator: 1'b0});
        seq.push_back('{char_in: rand_hex_char(), is_terminator: 1'b0});
      end else if (pick < 40) begin
        seq.push_back('{char_in: CH_PERCENT, is_terminator: 1'b0});
        seq.push_back('{char_in: CH_ZERO, is_terminator: 1'b0});
        seq.push_back('{char_in: CH_ZERO, is_terminator: 1'b0});
      end else if (pick < 60) begin
        seq.push_back('{char_in: 8'($urandom_range(0, 255)), is_terminator: 1'b0});
      end else if (pick < 68) begin
        seq.push_back('{char_in: CH_PLUS, is_terminator: 1'b0});
      end else if (pick < 76) begin
        seq.push_back('{char_in: CH_PERCENT, is_terminator: 1'b0});
        seq.push_back('{char_in: 8'($urandom_range(0, 255)), is_terminator: 1'b0});
      end else if (pick < 84) begin
        seq.push_back('{char_in: CH_PERCENT, is_terminator: 1'b0});
        seq.push_back('{char_in: rand_hex_char(), is_terminator: 1'b0});
        seq.push_back('{char_in: 8'($urandom_range(0, 255)), is_terminator: 1'b0});
      end else if (pick < 90) begin
        seq.push_back('{char_in: 8'($urandom_range(0, 255)), is_terminator: 1'b1});
      end else if (pick < 95) begin
        // Escape cut short by the end of the string.
        seq.push_back('{char_in: CH_PERCENT, is_terminator: 1'b0});
        if ($urandom_range(0, 1) == 1) begin
          seq.push_back('{char_in: rand_hex_char(), is_terminator: 1'b0});
        end
        seq.push_back('{char_in: 8'($urandom_range(0, 255)), is_terminator: 1'b1});
      end else begin
        seq.push_back('{char_in: 8'($urandom_range(8'h20, 8'h7e)), is_terminator: 1'b0});
      end
      foreach (seq[i]) begin
        deliver_and_predict(seq[i]);
      end
      sent += seq.size();
    end
  endtask

  task automatic flag_mismatch(input string why, input out_t want, input out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected char %h eos %b last %b, got char %h eos %b last %b",
               $realtime, why, want.char_out, want.end_of_string, want.last_of_run,
               got.char_out, got.end_of_string, got.last_of_run);
    end
  endtask

  // Output side: random stall bursts while bursts are enabled.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Each result transfer is checked against the oldest owed result.
  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (decoded_q.size() == 0) begin
        flag_mismatch("unexpected result", '0, out_data);
      end else begin
        want = decoded_q.pop_front();
        if (out_data.char_out !== want.char_out
            || out_data.end_of_string !== want.end_of_string
            || out_data.last_of_run !== want.last_of_run) begin
          flag_mismatch("result mismatch", want, out_data);
        end
      end
    end
  end

  // Main sequence: directed table, then random phases under both plus modes.
  initial begin
    in_t it;
    dir_rows = '{
      '{8'h41,      1'b0, 1'b1, 2'd1, 8'h41,      8'h00,    8'h00},
      '{8'h00,      1'b0, 1'b1, 2'd1, 8'h00,      8'h00,    8'h00},
      '{8'hFF,      1'b0, 1'b1, 2'd1, 8'hFF,      8'h00,    8'h00},
      '{CH_PLUS,    1'b0, 1'b1, 2'd1, CH_SPACE,   8'h00,    8'h00},
      // A complete escape, then one with mixed-case digits.
      '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'h34,      1'b0, 1'b1, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'h31,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      '{CH_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'h66,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'h46,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      // An escape of zero comes out literally.
      '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,    8'h00},
      '{CH_ZERO,    1'b0, 1'b1, 2'd0, 8'h00,      8'h00,    8'h00},
      '{CH_ZERO,    1'b0, 1'b1, 2'd3, CH_PERCENT, CH_ZERO,  CH_ZERO},
      // Non-hex after the percent.
      '{CH_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'h47,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      // Percent reopens an escape; then a bad second digit.
      '{CH_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      '{CH_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'h61,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'h7A,      1'b0, 1'b0, 2'd0, 8'h00,      8'h00,    8'h00},
      // Terminators in the middle of an escape flush it first.
      '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'hA5,      1'b1, 1'b1, 2'd2, CH_PERCENT, 8'h00,    8'h00},
      '{CH_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'h42,      1'b0, 1'b1, 2'd0, 8'h00,      8'h00,    8'h00},
      '{8'hFF,      1'b1, 1'b1, 2'd3, CH_PERCENT, 8'h42,    8'h00},
      '{8'h00,      1'b1, 1'b1, 2'd1, 8'h00,      8'h00,    8'h00}
    };
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      it = '{char_in: dir_rows[i].ch, is_terminator: dir_rows[i].term};
      deliver(it);
      decode_step(it);
      if (dir_rows[i].known_run) begin
        run_len = int'(dir_rows[i].run_cnt);
        run_buf[0] = '{char_out: dir_rows[i].r0, end_of_string: 1'b0, last_of_run: 1'b0};
        run_buf[1] = '{char_out: dir_rows[i].r1, end_of_string: 1'b0, last_of_run: 1'b0};
        run_buf[2] = '{char_out: dir_rows[i].r2, end_of_string: 1'b0, last_of_run: 1'b0};
        if (run_len > 0) begin
          run_buf[run_len - 1].last_of_run = 1'b1;
          run_buf[run_len - 1].end_of_string = dir_rows[i].term;
        end
      end
      queue_run();
    end

    set_plus_mode(1'b0, 1'b1);
    run_random(ITEMS_PER_PHASE);
    set_plus_mode(1'b1, 1'b1);
    run_random(ITEMS_PER_PHASE);
    set_plus_mode(1'b0, 1'b1);
    run_random(ITEMS_PER_PHASE);
    // Last stretch runs with no idle or stall bursts on either side.
    set_plus_mode(1'b1, 1'b0);
    run_random(ITEMS_PER_PHASE);

    in_valid <= 1'b0;
    while (decoded_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[url_percent_decoder] OK");
    end else begin
      $display("[url_percent_decoder] ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #500000;
    $display("[url_percent_decoder] ERROR");
    $finish;
  end

endmodule
